FILE: rtl/illfl_pkg.sv
// shared types and constants for the indexed linked list with free list
// no dependencies; imported by illfl_store, illfl_seq and the top level
package illfl_pkg;

  // default slot count of the store
  localparam int CAPACITY_DEF = 16;

  // fixed field widths of the stream beats
  localparam int POS_W       = 5;
  localparam int VAL_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // request kind
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_OOB   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ALLOC,
    S_ICHK,
    S_IHOP,
    S_ILINK,
    S_ISPLICE,
    S_DHEAD,
    S_DWALK,
    S_DGONE,
    S_DFREE,
    S_RESP
  } state_t;

  // one result item
  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
  } res_t;

endpackage

FILE: rtl/illfl_store.sv
// slot store: link memory and data memory, registered link read
// uses illfl_pkg; a fill count stands in for the reset chain of the links
module illfl_store #(
  parameter int CAPACITY = illfl_pkg::CAPACITY_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       rd_en,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
  output logic [$clog2(CAPACITY + 1)-1:0]            rd_link,
  input  logic                                       wr_en,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
  input  logic [$clog2(CAPACITY + 1)-1:0]            wr_link,
  input  logic                                       dwr_en,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] dwr_addr,
  input  logic [illfl_pkg::VAL_W-1:0]                dwr_data
);
  import illfl_pkg::*;

  localparam int LINK_W = $clog2(CAPACITY + 1);

  logic [LINK_W-1:0] link_mem [CAPACITY];
  logic [VAL_W-1:0]  data_mem [CAPACITY];

  logic [LINK_W-1:0] fill_r;
  logic [LINK_W-1:0] fill_nxt;
  logic [LINK_W-1:0] q_r;
  logic [LINK_W-1:0] inc_r;
  logic              untouched_r;

  // slots at or above the fill count were never written and still hold
  // their reset link, which is the next slot index
  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && (LINK_W'(wr_addr) == fill_r)) begin
      fill_nxt = fill_r + LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // link memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (rd_en) begin
      q_r         <= link_mem[rd_addr];
      inc_r       <= LINK_W'(rd_addr) + LINK_W'(1);
      untouched_r <= (LINK_W'(rd_addr) >= fill_r);
    end
  end

  // data memory, written by inserts
  always_ff @(posedge clk) begin
    if (dwr_en) begin
      data_mem[dwr_addr] <= dwr_data;
    end
  end

  assign rd_link = untouched_r ? inc_r : q_r;

endmodule

FILE: rtl/illfl_seq.sv
// request sequencer: allocation, link walk, splice and free list return
// uses illfl_pkg; drives the ports of illfl_store
module illfl_seq #(
  parameter int CAPACITY = illfl_pkg::CAPACITY_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  illfl_pkg::op_t                             in_op,
  input  logic [illfl_pkg::POS_W-1:0]                in_pos,
  input  logic [illfl_pkg::VAL_W-1:0]                in_val,
  output logic                                       res_valid,
  input  logic                                       res_ready,
  output illfl_pkg::res_t                            res,
  output logic                                       rd_en,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
  input  logic [$clog2(CAPACITY + 1)-1:0]            rd_link,
  output logic                                       wr_en,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
  output logic [$clog2(CAPACITY + 1)-1:0]            wr_link,
  output logic                                       dwr_en,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] dwr_addr,
  output logic [illfl_pkg::VAL_W-1:0]                dwr_data
);
  import illfl_pkg::*;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

  function automatic logic is_nil(input logic [LINK_W-1:0] x);
    return x >= NIL;
  endfunction

  function automatic logic [LINK_W-1:0] norm(input logic [LINK_W-1:0] x);
    return is_nil(x) ? NIL : x;
  endfunction

  function automatic logic [IDX_W-1:0] idx_of(input logic [LINK_W-1:0] x);
    return x[IDX_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] s);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, s};
    return ext[SLOT_W-1:0];
  endfunction

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [LINK_W-1:0]  list_head_r, list_head_nxt;
  logic [LINK_W-1:0]  free_head_r, free_head_nxt;
  logic [IDX_W-1:0]   fresh_r, fresh_nxt;
  logic [LINK_W-1:0]  walk_r, walk_nxt;
  logic [POS_W-1:0]   cnt_r, cnt_nxt;
  res_t               res_r, res_nxt;

  logic [LINK_W-1:0]  nxt_link;
  logic               hop_more;

  // link just read, with any out-of-range value taken as null
  assign nxt_link = norm(rd_link);
  // more hops are needed while cnt + 1 < position
  assign hop_more = ({1'b0, cnt_r} + (POS_W + 1)'(1)) < {1'b0, pos_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        if (op_r == OP_INSERT) begin
          state_nxt = is_nil(free_head_r) ? S_RESP : S_ALLOC;
        end else if (is_nil(list_head_r)) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = (pos_r == '0) ? S_DHEAD : S_DWALK;
        end
      end
      S_ALLOC:   state_nxt = (pos_r == '0) ? S_RESP : S_ICHK;
      S_ICHK: begin
        if (is_nil(walk_r))  state_nxt = S_RESP;
        else if (hop_more)   state_nxt = S_IHOP;
        else                 state_nxt = S_ILINK;
      end
      S_IHOP:    state_nxt = S_ICHK;
      S_ILINK:   state_nxt = S_ISPLICE;
      S_ISPLICE: state_nxt = S_RESP;
      S_DHEAD:   state_nxt = S_RESP;
      S_DWALK: begin
        if (is_nil(nxt_link)) state_nxt = S_RESP;
        else if (hop_more)    state_nxt = S_DWALK;
        else                  state_nxt = S_DGONE;
      end
      S_DGONE:   state_nxt = S_DFREE;
      S_DFREE:   state_nxt = S_RESP;
      S_RESP: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // store accesses and register updates per state
  always_comb begin
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    list_head_nxt = list_head_r;
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    walk_nxt      = walk_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    rd_en         = 1'b0;
    rd_addr       = idx_of(walk_r);
    wr_en         = 1'b0;
    wr_addr       = fresh_r;
    wr_link       = free_head_r;
    dwr_en        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_op;
          pos_nxt = in_pos;
          val_nxt = in_val;
        end
      end
      S_START: begin
        if (op_r == OP_INSERT) begin
          if (is_nil(free_head_r)) begin
            res_nxt = '{status: ST_FULL, slot: '0};
          end else begin
            rd_en     = 1'b1;
            rd_addr   = idx_of(free_head_r);
            fresh_nxt = idx_of(free_head_r);
          end
        end else if (is_nil(list_head_r)) begin
          res_nxt = '{status: ST_EMPTY, slot: '0};
        end else begin
          walk_nxt = list_head_r;
          cnt_nxt  = '0;
          rd_en    = 1'b1;
          rd_addr  = idx_of(list_head_r);
        end
      end
      // take the front free slot and store the value; at position zero link it in as the new head
      S_ALLOC: begin
        free_head_nxt = nxt_link;
        dwr_en        = 1'b1;
        if (pos_r == '0) begin
          wr_en         = 1'b1;
          wr_addr       = fresh_r;
          wr_link       = list_head_r;
          list_head_nxt = LINK_W'(fresh_r);
          res_nxt       = '{status: ST_DONE, slot: slot_of(fresh_r)};
        end else begin
          walk_nxt = list_head_r;
          cnt_nxt  = '0;
        end
      end
      // walk ran off the end: hand the slot back to the free list; else read the current link
      S_ICHK: begin
        if (is_nil(walk_r)) begin
          wr_en         = 1'b1;
          wr_addr       = fresh_r;
          wr_link       = free_head_r;
          free_head_nxt = LINK_W'(fresh_r);
          res_nxt       = '{status: ST_OOB, slot: '0};
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_of(walk_r);
        end
      end
      S_IHOP: begin
        walk_nxt = nxt_link;
        cnt_nxt  = cnt_r + POS_W'(1);
      end
      S_ILINK: begin
        wr_en   = 1'b1;
        wr_addr = fresh_r;
        wr_link = nxt_link;
      end
      S_ISPLICE: begin
        wr_en   = 1'b1;
        wr_addr = idx_of(walk_r);
        wr_link = LINK_W'(fresh_r);
        res_nxt = '{status: ST_DONE, slot: slot_of(fresh_r)};
      end
      // unlink the head and push it on the free list
      S_DHEAD: begin
        list_head_nxt = nxt_link;
        wr_en         = 1'b1;
        wr_addr       = idx_of(walk_r);
        wr_link       = free_head_r;
        free_head_nxt = walk_r;
        res_nxt       = '{status: ST_DONE, slot: slot_of(idx_of(walk_r))};
      end
      S_DWALK: begin
        if (is_nil(nxt_link)) begin
          res_nxt = '{status: ST_OOB, slot: '0};
        end else if (hop_more) begin
          walk_nxt = nxt_link;
          cnt_nxt  = cnt_r + POS_W'(1);
          rd_en    = 1'b1;
          rd_addr  = idx_of(nxt_link);
        end else begin
          fresh_nxt = idx_of(nxt_link);
          rd_en     = 1'b1;
          rd_addr   = idx_of(nxt_link);
        end
      end
      S_DGONE: begin
        wr_en   = 1'b1;
        wr_addr = idx_of(walk_r);
        wr_link = nxt_link;
      end
      S_DFREE: begin
        wr_en         = 1'b1;
        wr_addr       = fresh_r;
        wr_link       = free_head_r;
        free_head_nxt = LINK_W'(fresh_r);
        res_nxt       = '{status: ST_DONE, slot: slot_of(fresh_r)};
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;
  assign dwr_addr  = fresh_r;
  assign dwr_data  = val_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= NIL;
      free_head_r <= '0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
    end
  end

  // request payload and walk registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    fresh_r <= fresh_nxt;
    walk_r  <= walk_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
  end

endmodule

FILE: rtl/indexed_linked_list_free_list.sv
// one request at a time; a full store, an empty list or position zero is
// answered without a walk, else the request walks the links towards its
// position, with one dependent read of the link store per hop
// the next request is taken once the result sits in the output register
// reset: synchronous, active low; list empty, free list from slot zero,
// the link store needs no clearing pass (a fill count supplies reset links)
module indexed_linked_list_free_list #(
  parameter int CAPACITY = illfl_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [4:0] position, [36:5] value, [39:37] zero
  input  logic [illfl_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] operation
  input  logic [0:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [1:0] status, [5:2] slot, [7:6] zero
  output logic [illfl_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import illfl_pkg::*;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W = $clog2(CAPACITY + 1);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [LINK_W-1:0] rd_link;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [LINK_W-1:0] wr_link;
  logic              dwr_en;
  logic [IDX_W-1:0]  dwr_addr;
  logic [VAL_W-1:0]  dwr_data;

  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  illfl_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tuser[0])),
    .in_pos    (in_tdata[POS_W-1:0]),
    .in_val    (in_tdata[POS_W+VAL_W-1:POS_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_link   (rd_link),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_link   (wr_link),
    .dwr_en    (dwr_en),
    .dwr_addr  (dwr_addr),
    .dwr_data  (dwr_data)
  );

  illfl_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_link  (rd_link),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_link  (wr_link),
    .dwr_en   (dwr_en),
    .dwr_addr (dwr_addr),
    .dwr_data (dwr_data)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - STATUS_W - SLOT_W){1'b0}},
                       out_res_r.slot, out_res_r.status};

  // a failed request reports slot zero
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status != ST_DONE) |-> (out_res_r.slot == '0))
    else $error("failed request reports a non-zero slot");

  // no second request is taken while one is being worked on
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while the sequencer is busy");

  // no result may be pending when a new request is taken
  a_no_pending_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !res_valid)
    else $error("request accepted with a result still pending");

endmodule
